// File: hw/rtl/pnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_pkg
// Shared sizes, types and constants of the nearest palette colour search.
// ----------------------------------------------------------------------------
package pnc_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
   localparam int COMP_W          = 8;
   localparam int COLOUR_W        = 3 * COMP_W;
   localparam int SQ_W            = 2 * COMP_W;

   // largest distance is 3*255*255, which fits in this width
   localparam int MAX_DIST        = 3 * 255 * 255;
   localparam int DIST_W          = $clog2(MAX_DIST + 1);

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_MATCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

endpackage

// File: hw/rtl/palette_nearest_color_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_nearest_color_match
// Palette store with a nearest-colour search over every entry, one distance
// per cycle through a three-stage read / square / compare datapath.
// ----------------------------------------------------------------------------
//
//   channel   handshake           payload
//   request   start, busy         req_type, req_entry_index, req_red/green/blue
//   response  rsp_valid (1 cyc)   rsp_match_index
//
// A write transfer is stored at the accepting edge and busy stays low. A
// match transfer keeps busy high while every entry is read, one palette read
// per cycle, and while the square and compare stages empty; then the winning
// index is latched and the response is strobed in the first cycle with busy
// low. Reset clears the valid bit of every entry at once, so no clearing pass
// is needed. The receiver cannot stall the response.
//
module palette_nearest_color_match (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_type,
   input  logic [7:0] req_entry_index,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   output logic [7:0] rsp_match_index
);

   localparam int N     = pnc_pkg::PALETTE_ENTRIES;
   localparam int IW    = pnc_pkg::IDX_W;
   localparam int CW    = pnc_pkg::COMP_W;
   localparam int SW    = pnc_pkg::SQ_W;
   localparam int DW    = pnc_pkg::DIST_W;

   pnc_pkg::state_type state_ff, state_in;

   logic [pnc_pkg::COLOUR_W-1:0] mem [N];
   logic [N-1:0]                 vld_ff;

   logic [IW-1:0]                cnt_ff, cnt_in;
   logic [pnc_pkg::COLOUR_W-1:0] ref_ff;

   // stage 1: registered palette read
   logic                         s1_vld_ff;
   logic [IW-1:0]                s1_idx_ff;
   logic [pnc_pkg::COLOUR_W-1:0] s1_rd_ff;
   logic                         s1_ent_ff;

   // stage 2: registered squares
   logic                         s2_vld_ff;
   logic [IW-1:0]                s2_idx_ff;
   logic [SW-1:0]                s2_sq_r_ff, s2_sq_g_ff, s2_sq_b_ff;

   // stage 3: running best
   logic [DW-1:0]                best_ff, best_in;
   logic [IW-1:0]                best_idx_ff, best_idx_in;

   logic                         rsp_valid_ff;
   logic [7:0]                   rsp_index_ff;

   logic                         accept, wr_ok;
   logic [pnc_pkg::COLOUR_W-1:0] colour;
   logic [CW-1:0]                d_r, d_g, d_b;
   logic [DW-1:0]                dist_sum;

   assign accept = start && !busy;
   assign busy   = (state_ff != pnc_pkg::ST_IDLE);

   // entry 0 and the last entry are reserved, and indexes past the palette drop
   assign wr_ok  = (req_entry_index != 8'd0) && (9'(req_entry_index) < 9'(N - 1));

   always_ff @(posedge clock) begin
      if (accept && req_type == pnc_pkg::REQ_WRITE && wr_ok) begin
         mem[req_entry_index[IW-1:0]] <= {req_red, req_green, req_blue};
      end
      s1_rd_ff <= mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (accept && req_type == pnc_pkg::REQ_WRITE && wr_ok) begin
         vld_ff[req_entry_index[IW-1:0]] <= 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         pnc_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (accept && req_type == pnc_pkg::REQ_MATCH) begin
               state_in = pnc_pkg::ST_SCAN;
            end
         end
         pnc_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IW'(N - 1)) begin
               state_in = pnc_pkg::ST_DRAIN;
            end
         end
         pnc_pkg::ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = pnc_pkg::ST_IDLE;
            end
         end
         default: state_in = pnc_pkg::ST_IDLE;
      endcase
   end

   // unwritten entries read as black
   assign colour = s1_ent_ff ? s1_rd_ff : '0;

   always_comb begin
      d_r = (colour[23:16] >= ref_ff[23:16]) ? colour[23:16] - ref_ff[23:16]
                                             : ref_ff[23:16] - colour[23:16];
      d_g = (colour[15:8] >= ref_ff[15:8]) ? colour[15:8] - ref_ff[15:8]
                                           : ref_ff[15:8] - colour[15:8];
      d_b = (colour[7:0] >= ref_ff[7:0]) ? colour[7:0] - ref_ff[7:0]
                                         : ref_ff[7:0] - colour[7:0];
   end

   assign dist_sum = DW'(s2_sq_r_ff) + DW'(s2_sq_g_ff) + DW'(s2_sq_b_ff);

   always_comb begin
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (state_ff == pnc_pkg::ST_IDLE) begin
         // all-ones lies above every distance, so entry 0 always takes it
         best_in     = '1;
         best_idx_in = '0;
      end else if (s2_vld_ff && dist_sum < best_ff) begin
         best_in     = dist_sum;
         best_idx_in = s2_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pnc_pkg::ST_IDLE;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_vld_ff    <= (state_ff == pnc_pkg::ST_SCAN);
         s2_vld_ff    <= s1_vld_ff;
         rsp_valid_ff <= (state_ff == pnc_pkg::ST_DRAIN) && !s1_vld_ff && !s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      if (accept) begin
         ref_ff <= {req_red, req_green, req_blue};
      end
      s1_idx_ff  <= cnt_ff;
      s1_ent_ff  <= vld_ff[cnt_ff];
      s2_idx_ff  <= s1_idx_ff;
      s2_sq_r_ff <= SW'(d_r) * SW'(d_r);
      s2_sq_g_ff <= SW'(d_g) * SW'(d_g);
      s2_sq_b_ff <= SW'(d_b) * SW'(d_b);
      if ((state_ff == pnc_pkg::ST_DRAIN) && !s1_vld_ff && !s2_vld_ff) begin
         rsp_index_ff <= 8'(best_idx_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_index = rsp_index_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while a search is still running");

   a_match_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == pnc_pkg::REQ_MATCH) |=> busy)
      else $error("match transfer did not start a search");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response held for more than one cycle");

   a_pipe_busy: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> (state_ff == pnc_pkg::ST_DRAIN || state_ff == pnc_pkg::ST_SCAN))
      else $error("compare stage active outside a search");

endmodule

// File: tb/sv/palette_nearest_color_match_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_nearest_color_match_tb
// Drives palette writes and nearest-colour searches into the block, keeps its
// own copy of the palette and works out the expected entry index for every
// search. Each search response is compared with the oldest outstanding
// expectation. Directed cases cover the reset palette, the reserved first and
// last entries, exact hits, ties and the colour extremes; random phases then
// cover full-range palettes, tie-heavy narrow palettes and write bursts
// followed by searches near stored colours.
// ----------------------------------------------------------------------------
module palette_nearest_color_match_tb;

   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int unsigned SEARCH_BOUND   = 32'hff * 32'hff * 32'hff;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } colour_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       start           = 1'b0;
   logic       req_type        = pnc_pkg::REQ_WRITE;
   logic [7:0] req_entry_index = 8'd0;
   logic [7:0] req_red         = 8'd0;
   logic [7:0] req_green       = 8'd0;
   logic [7:0] req_blue        = 8'd0;
   logic       busy;
   logic       rsp_valid;
   logic [7:0] rsp_match_index;

   colour_type palette_model [pnc_pkg::PALETTE_ENTRIES];
   logic [7:0] nearest_queue [$];
   int         errors         = 0;
   int         writes_stored  = 0;
   int         writes_dropped = 0;
   int         searches       = 0;
   int         idle_cycles    = 0;
   bit         no_idle        = 1'b0;

   palette_nearest_color_match uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_match_index (rsp_match_index)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic logic [7:0] nearest_entry_of(colour_type want);
      int unsigned best_dist;
      int unsigned dist_sum;
      int          best_idx;
      int          dr;
      int          dg;
      int          db;
      best_dist = SEARCH_BOUND;
      best_idx  = 0;
      for (int i = 0; i < pnc_pkg::PALETTE_ENTRIES; i++) begin
         dr       = int'(palette_model[i].red)   - int'(want.red);
         dg       = int'(palette_model[i].green) - int'(want.green);
         db       = int'(palette_model[i].blue)  - int'(want.blue);
         dist_sum = dr * dr + dg * dg + db * db;
         // strict compare keeps the lowest index on a tie
         if (dist_sum < best_dist) begin
            best_dist = dist_sum;
            best_idx  = i;
         end
      end
      return best_idx[7:0];
   endfunction

   function automatic bit entry_reserved(logic [7:0] index);
      return index == 0 || int'(index) >= pnc_pkg::PALETTE_ENTRIES
          || int'(index) == pnc_pkg::PALETTE_ENTRIES - 1;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic colour_type random_colour();
      colour_type c;
      c = colour_type'(24'($urandom_range(0, 24'hffffff)));
      return c;
   endfunction

   function automatic colour_type narrow_colour();
      colour_type c;
      c.red   = 8'($urandom_range(0, 3));
      c.green = 8'($urandom_range(0, 3));
      c.blue  = 8'($urandom_range(0, 3));
      return c;
   endfunction

   function automatic logic [7:0] clamp_component(int value);
      if (value < 0) begin
         return 8'd0;
      end
      if (value > 255) begin
         return 8'd255;
      end
      return 8'(value);
   endfunction

   function automatic colour_type colour_near(colour_type c, int spread);
      colour_type n;
      n.red   = clamp_component(int'(c.red)   + int'($urandom_range(0, 2 * spread)) - spread);
      n.green = clamp_component(int'(c.green) + int'($urandom_range(0, 2 * spread)) - spread);
      n.blue  = clamp_component(int'(c.blue)  + int'($urandom_range(0, 2 * spread)) - spread);
      return n;
   endfunction

   // mostly ordinary entries, now and then one of the reserved ends
   function automatic logic [7:0] pick_entry();
      if ($urandom_range(0, 15) == 0) begin
         return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // one transfer on the request channel, then update the palette copy or queue the expected index
   task automatic send_item(input logic kind, input logic [7:0] index, input colour_type c);
      int gap;
      if ($urandom_range(0, 39) == 0) begin
         no_idle = !no_idle;
      end
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         start <= 1'b0;
         // sometimes hold the gap until the search has finished
         if ($urandom_range(0, 1) == 1) begin
            @(posedge clock);
            while (busy) @(posedge clock);
         end
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_entry_index <= index;
      req_red         <= c.red;
      req_green       <= c.green;
      req_blue        <= c.blue;
      do @(posedge clock); while (busy);
      if (kind == pnc_pkg::REQ_WRITE) begin
         if (entry_reserved(index)) begin
            writes_dropped++;
         end else begin
            palette_model[index] = c;
            writes_stored++;
         end
      end else begin
         nearest_queue.push_back(nearest_entry_of(c));
         searches++;
      end
   endtask

   task automatic send_write(input logic [7:0] index, input colour_type c);
      send_item(pnc_pkg::REQ_WRITE, index, c);
   endtask

   task automatic send_search(input colour_type c);
      send_item(pnc_pkg::REQ_MATCH, 8'($urandom_range(0, 255)), c);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_reset_palette();
      send_item(pnc_pkg::REQ_MATCH, 8'h00, 24'h000000);
      send_item(pnc_pkg::REQ_MATCH, 8'hff, 24'hffffff);
   endtask

   task automatic test_reserved_entries();
      send_write(8'd0, 24'hffffff);
      send_write(8'd255, 24'hffffff);
      send_search(24'hffffff);
   endtask

   task automatic test_directed_search();
      // identical entries: lower index wins
      send_write(8'd1, 24'hffffff);
      send_write(8'd254, 24'hffffff);
      send_search(24'hffffff);
      // exact hit with the index field set on a search
      send_write(8'd128, 24'h8040c0);
      send_item(pnc_pkg::REQ_MATCH, 8'ha5, 24'h8040c0);
      // equal distance from two entries
      send_write(8'd10, 24'h0a0a0a);
      send_write(8'd20, 24'h1e1e1e);
      send_search(24'h141414);
      send_write(8'd2, 24'hff0000);
      send_write(8'd3, 24'h00ff00);
      send_write(8'd4, 24'h0000ff);
      send_search(24'hff0000);
      send_search(24'h00ff00);
      send_search(24'h0000ff);
      send_search(24'h7f7f7f);
      send_search(24'h000000);
   endtask

   task automatic test_random_palette(input int count);
      colour_type c;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9)) inside
            [0:4]: begin
               send_write(pick_entry(), random_colour());
            end
            [5:7]: begin
               c = colour_near(palette_model[$urandom_range(0, 255)], $urandom_range(0, 16));
               send_search(c);
            end
            default: begin
               send_search(random_colour());
            end
         endcase
      end
   endtask

   // tiny colour range so equal distances are common
   task automatic test_random_ties(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 1) == 0) begin
            send_write(pick_entry(), narrow_colour());
         end else begin
            send_search(narrow_colour());
         end
      end
   endtask

   task automatic test_random_bursts(input int count);
      colour_type base;
      colour_type c;
      int         n;
      n = 0;
      while (n < count) begin
         base = random_colour();
         repeat ($urandom_range(4, 24)) begin
            c = $urandom_range(0, 1) ? colour_near(base, 12) : random_colour();
            send_write(pick_entry(), c);
            n++;
         end
         repeat ($urandom_range(2, 8)) begin
            if ($urandom_range(0, 3) == 0) begin
               c = random_colour();
            end else begin
               c = colour_near(palette_model[$urandom_range(0, 255)], $urandom_range(0, 20));
            end
            send_search(c);
            n++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_search_result
      logic [7:0] want;
      if (!reset && rsp_valid) begin
         if (nearest_queue.size() == 0) begin
            $error("unexpected result transfer: match_index actual %0d", rsp_match_index);
            errors++;
         end else begin
            want = nearest_queue.pop_front();
            if (rsp_match_index !== want) begin
               $error("match_index: expected %0d, actual %0d", want, rsp_match_index);
               errors++;
            end
         end
      end
   end

   // no transfer on either channel for too long means the block has hung
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < pnc_pkg::PALETTE_ENTRIES; i++) begin
         palette_model[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_palette();
      test_reserved_entries();
      test_directed_search();
      test_random_palette(700);
      test_random_ties(500);
      test_random_bursts(600);

      start <= 1'b0;
      while (nearest_queue.size() != 0) @(posedge clock);
      repeat (pnc_pkg::PALETTE_ENTRIES + 8) @(posedge clock);

      $display("covered %0d stored palette writes, %0d writes to reserved entries",
               writes_stored, writes_dropped);
      $display("and %0d nearest-colour searches", searches);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
